// ===== rtl/hfs_pkg.sv =====
// Package of the scaled HMM forward filter: sizes, field widths and item kind codes.
// Used by hmm_forward_scaled_unit and the testbench; depends on nothing.
package hfs_pkg;

   localparam int NUM_STATES  = 8;
   localparam int NUM_SYMBOLS = 16;

   localparam int STATE_W     = $clog2(NUM_STATES);
   localparam int TRANS_DEPTH = NUM_STATES * NUM_STATES;
   localparam int EMIT_DEPTH  = NUM_STATES * NUM_SYMBOLS;
   localparam int TRANS_AW    = $clog2(TRANS_DEPTH);
   localparam int EMIT_AW     = $clog2(EMIT_DEPTH);

   localparam int KIND_W  = 2;
   localparam int ROW_W   = 3;
   localparam int COL_W   = 4;
   localparam int PROB_W  = 16;
   localparam int SYMF_W  = 4;
   localparam int ALPHA_W = 17;

   localparam int SUM_W   = ALPHA_W + $clog2(NUM_STATES);
   localparam int ACC_W   = ALPHA_W + PROB_W + $clog2(NUM_STATES);
   localparam int MUL_AW  = ACC_W - PROB_W;
   localparam int MUL_W   = MUL_AW + PROB_W;
   localparam int K_W     = $clog2(NUM_STATES + 2);
   localparam int STEP_W  = $clog2(ALPHA_W + 1);

   localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);

   localparam logic [KIND_W-1:0] KIND_TRANS   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EMIT    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INIT    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OBSERVE = 2'd3;

endpackage

// ===== rtl/hfs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; instanced for every table of the forward filter.
module hfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hmm_forward_scaled_unit.sv =====
// Top level of the scaled HMM forward filter: table RAMs, MAC sequencer and serial divider.
// Depends on hfs_pkg and hfs_ram.
//
// Write beats (kind 0..2) return nothing. An observe beat (kind 3) runs one shared
// multiply-accumulate unit over the RAMs for each state (init times emission at sequence
// start), then a restoring divider gives each normalized alpha, then the N result beats
// leave while the sink is ready. The next beat is taken once the last result of the step
// sits in the output register.
module hmm_forward_scaled_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // row[2:0], col[6:3], prob_value[22:7], symbol[26:23], seq_start[27], zero fill.
   input  logic [31:0] req_tdata,
   // kind[1:0].
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // state_index[2:0], alpha_value[19:3], scale[36:20], zero fill.
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MAC    = 3'd1;
   localparam logic [2:0] ST_DIV_RD = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_OUT_RD = 3'd4;
   localparam logic [2:0] ST_OUT_LD = 3'd5;

   localparam int SW = hfs_pkg::STATE_W;
   localparam int AW = hfs_pkg::ALPHA_W;
   localparam int PW = hfs_pkg::PROB_W;
   localparam int SUMW = hfs_pkg::SUM_W;

   logic [2:0]                  state_ff, state_in;
   logic [SW-1:0]               j_ff, j_in;
   logic [hfs_pkg::K_W-1:0]     k_ff, k_in;
   logic                        start_ff, start_in;
   logic [hfs_pkg::SYMF_W-1:0]  sym_ff, sym_in;
   logic [hfs_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [SUMW-1:0]             sum_ff, sum_in;
   logic [SUMW-1:0]             rem_ff, rem_in;
   logic [AW-1:0]               quo_ff, quo_in;
   logic                        ulow_ff, ulow_in;
   logic [hfs_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [hfs_pkg::NUM_STATES-1:0] avalid_ff, avalid_in;
   logic                        arvalid_ff;
   logic                        ovalid_ff, ovalid_in;
   logic [SW-1:0]               oidx_ff, oidx_in;
   logic [AW-1:0]               oalpha_ff, oalpha_in;
   logic [AW-1:0]               oscale_ff, oscale_in;
   logic                        olast_ff, olast_in;

   logic [hfs_pkg::ROW_W-1:0]   f_row;
   logic [hfs_pkg::COL_W-1:0]   f_col;
   logic [PW-1:0]               f_prob;
   logic [hfs_pkg::SYMF_W-1:0]  f_sym;
   logic                        f_start;
   logic                        accept, row_ok, last_j;

   logic                        trans_we, emit_we, init_we, unsc_we, alpha_we;
   logic [hfs_pkg::TRANS_AW-1:0] trans_wa, trans_ra;
   logic [hfs_pkg::EMIT_AW-1:0]  emit_wa, emit_ra;
   logic [SW-1:0]               init_wa, alpha_ra;
   logic [PW-1:0]               trans_rd, emit_rd, init_rd;
   logic [AW-1:0]               alpha_rd, unsc_rd, alpha_wd, u_sat;
   logic [PW-1:0]               e_val;
   logic [AW-1:0]               alpha_q;
   logic [hfs_pkg::MUL_AW-1:0]  mul_a;
   logic [hfs_pkg::MUL_W-1:0]   mul_p;
   logic [SUMW:0]               trial;
   logic [AW-1:0]               scale_sat;

   assign f_row   = req_tdata[2:0];
   assign f_col   = req_tdata[6:3];
   assign f_prob  = req_tdata[22:7];
   assign f_sym   = req_tdata[26:23];
   assign f_start = req_tdata[27];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign row_ok     = 32'(f_row) < hfs_pkg::NUM_STATES;
   assign last_j     = (j_ff == SW'(hfs_pkg::NUM_STATES - 1));

   assign trans_we = accept && (req_tuser == hfs_pkg::KIND_TRANS) && row_ok
                     && (32'(f_col) < hfs_pkg::NUM_STATES);
   assign emit_we  = accept && (req_tuser == hfs_pkg::KIND_EMIT) && row_ok
                     && (32'(f_col) < hfs_pkg::NUM_SYMBOLS);
   assign init_we  = accept && (req_tuser == hfs_pkg::KIND_INIT) && row_ok;
   assign trans_wa = hfs_pkg::TRANS_AW'(32'(f_row) * hfs_pkg::NUM_STATES + 32'(f_col));
   assign emit_wa  = hfs_pkg::EMIT_AW'(32'(f_row) * hfs_pkg::NUM_SYMBOLS + 32'(f_col));
   assign init_wa  = SW'(f_row);

   assign trans_ra = hfs_pkg::TRANS_AW'(32'(k_ff) * hfs_pkg::NUM_STATES + 32'(j_ff));
   assign emit_ra  = hfs_pkg::EMIT_AW'(32'(j_ff) * hfs_pkg::NUM_SYMBOLS + 32'(sym_ff));
   assign alpha_ra = (state_ff == ST_MAC) ? SW'(k_ff) : j_ff;

   hfs_ram #(.WIDTH(PW), .DEPTH(hfs_pkg::TRANS_DEPTH)) u_trans (
      .clock(clock), .wr_en(trans_we), .wr_addr(trans_wa), .wr_data(f_prob),
      .rd_addr(trans_ra), .rd_data(trans_rd));
   hfs_ram #(.WIDTH(PW), .DEPTH(hfs_pkg::EMIT_DEPTH)) u_emit (
      .clock(clock), .wr_en(emit_we), .wr_addr(emit_wa), .wr_data(f_prob),
      .rd_addr(emit_ra), .rd_data(emit_rd));
   hfs_ram #(.WIDTH(PW), .DEPTH(hfs_pkg::NUM_STATES)) u_init (
      .clock(clock), .wr_en(init_we), .wr_addr(init_wa), .wr_data(f_prob),
      .rd_addr(j_ff), .rd_data(init_rd));
   hfs_ram #(.WIDTH(AW), .DEPTH(hfs_pkg::NUM_STATES)) u_unsc (
      .clock(clock), .wr_en(unsc_we), .wr_addr(j_ff), .wr_data(u_sat),
      .rd_addr(j_ff), .rd_data(unsc_rd));
   hfs_ram #(.WIDTH(AW), .DEPTH(hfs_pkg::NUM_STATES)) u_alpha (
      .clock(clock), .wr_en(alpha_we), .wr_addr(j_ff), .wr_data(alpha_wd),
      .rd_addr(alpha_ra), .rd_data(alpha_rd));

   assign alpha_q = arvalid_ff ? alpha_rd : '0;
   assign e_val   = (32'(sym_ff) < hfs_pkg::NUM_SYMBOLS) ? emit_rd : '0;
   assign mul_a   = start_ff ? hfs_pkg::MUL_AW'(init_rd)
                             : acc_ff[hfs_pkg::ACC_W-1:PW];
   assign mul_p   = hfs_pkg::MUL_W'(mul_a) * hfs_pkg::MUL_W'(e_val);
   assign u_sat   = (mul_p[hfs_pkg::MUL_W-1:PW] > hfs_pkg::MUL_AW'(hfs_pkg::ONE_Q16))
                    ? hfs_pkg::ONE_Q16 : mul_p[PW+AW-1:PW];
   assign trial   = {rem_ff, (step_ff == hfs_pkg::STEP_W'(1)) ? ulow_ff : 1'b0};
   assign scale_sat = (sum_ff > SUMW'(hfs_pkg::ONE_Q16)) ? hfs_pkg::ONE_Q16 : sum_ff[AW-1:0];

   always_comb begin
      state_in  = state_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      start_in  = start_ff;
      sym_in    = sym_ff;
      acc_in    = acc_ff;
      sum_in    = sum_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      ulow_in   = ulow_ff;
      step_in   = step_ff;
      avalid_in = avalid_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      oidx_in   = oidx_ff;
      oalpha_in = oalpha_ff;
      oscale_in = oscale_ff;
      olast_in  = olast_ff;
      unsc_we   = 1'b0;
      alpha_we  = 1'b0;
      alpha_wd  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == hfs_pkg::KIND_OBSERVE)) begin
               state_in = ST_MAC;
               start_in = f_start;
               sym_in   = f_sym;
               j_in     = '0;
               k_in     = '0;
               sum_in   = '0;
            end
         end
         ST_MAC: begin
            k_in = k_ff + 1'b1;
            if (!start_ff && k_ff >= hfs_pkg::K_W'(1)
                && k_ff <= hfs_pkg::K_W'(hfs_pkg::NUM_STATES)) begin
               acc_in = ((k_ff == hfs_pkg::K_W'(1)) ? '0 : acc_ff)
                        + hfs_pkg::ACC_W'(alpha_q) * hfs_pkg::ACC_W'(trans_rd);
            end
            if ((start_ff && k_ff == hfs_pkg::K_W'(1))
                || k_ff == hfs_pkg::K_W'(hfs_pkg::NUM_STATES + 1)) begin
               unsc_we = 1'b1;
               sum_in  = sum_ff + SUMW'(u_sat);
               k_in    = '0;
               j_in    = j_ff + 1'b1;
               if (last_j) begin
                  state_in = ST_DIV_RD;
                  j_in     = '0;
               end
            end
         end
         ST_DIV_RD: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == '0) begin
               rem_in  = SUMW'(unsc_rd[AW-1:1]);
               ulow_in = unsc_rd[0];
               quo_in  = '0;
            end else begin
               if (trial >= (SUMW+1)'(sum_ff)) begin
                  rem_in = SUMW'(trial - (SUMW+1)'(sum_ff));
                  quo_in = {quo_ff[AW-2:0], 1'b1};
               end else begin
                  rem_in = SUMW'(trial);
                  quo_in = {quo_ff[AW-2:0], 1'b0};
               end
               if (step_ff == hfs_pkg::STEP_W'(AW)) begin
                  alpha_we  = 1'b1;
                  alpha_wd  = (sum_ff == '0) ? '0 : quo_in;
                  avalid_in[j_ff] = 1'b1;
                  j_in      = j_ff + 1'b1;
                  state_in  = ST_DIV_RD;
                  if (last_j) begin
                     state_in = ST_OUT_RD;
                     j_in     = '0;
                  end
               end
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               oidx_in   = j_ff;
               oalpha_in = alpha_q;
               oscale_in = scale_sat;
               olast_in  = last_j;
               j_in      = j_ff + 1'b1;
               state_in  = last_j ? ST_IDLE : ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         avalid_ff <= '0;
         ovalid_ff <= 1'b0;
         j_ff      <= '0;
         k_ff      <= '0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         avalid_ff <= avalid_in;
         ovalid_ff <= ovalid_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         step_ff   <= step_in;
      end
      arvalid_ff <= avalid_ff[alpha_ra];
      start_ff   <= start_in;
      sym_ff     <= sym_in;
      acc_ff     <= acc_in;
      sum_ff     <= sum_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      ulow_ff    <= ulow_in;
      oidx_ff    <= oidx_in;
      oalpha_ff  <= oalpha_in;
      oscale_ff  <= oscale_in;
      olast_ff   <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {3'b000, oscale_ff, oalpha_ff, oidx_ff};

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench of hmm_forward_scaled_unit: loads the tables, sends observe beats,
// predicts each normalized forward step and checks every result beat. Depends on hfs_pkg.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  state_index;
      logic [16:0] alpha_value;
      logic [16:0] scale;
      logic        last;
   } alpha_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   logic [15:0] trans_mem [hfs_pkg::NUM_STATES*hfs_pkg::NUM_STATES];
   logic [15:0] emit_mem [hfs_pkg::NUM_STATES*hfs_pkg::NUM_SYMBOLS];
   logic [15:0] init_mem [hfs_pkg::NUM_STATES];
   logic [16:0] alpha_mem [hfs_pkg::NUM_STATES];
   alpha_beat_type alpha_queue [$];
   int          errors = 0;
   int          quiet_cycles = 0;
   int          stall_left = 0;
   bit          calm = 1'b0;

   hmm_forward_scaled_unit dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic forward_step(input logic [3:0] sym, input logic start);
      logic [63:0] u [hfs_pkg::NUM_STATES];
      logic [63:0] acc, sum, e;
      alpha_beat_type b;
      sum = 0;
      for (int j = 0; j < hfs_pkg::NUM_STATES; j++) begin
         e = 64'(emit_mem[j*hfs_pkg::NUM_SYMBOLS + sym]);
         if (start) begin
            u[j] = (64'(init_mem[j]) * e) >> 16;
         end else begin
            acc = 0;
            for (int i = 0; i < hfs_pkg::NUM_STATES; i++)
               acc += 64'(alpha_mem[i]) * 64'(trans_mem[i*hfs_pkg::NUM_STATES + j]);
            u[j] = ((acc >> 16) * e) >> 16;
         end
         if (u[j] > 65536) u[j] = 65536;
         sum += u[j];
      end
      for (int j = 0; j < hfs_pkg::NUM_STATES; j++) begin
         alpha_mem[j] = (sum != 0) ? 17'((u[j] << 16) / sum) : 17'(u[j]);
         b.state_index = 3'(j);
         b.alpha_value = alpha_mem[j];
         b.scale       = (sum > 65536) ? 17'(65536) : 17'(sum);
         b.last        = (j == hfs_pkg::NUM_STATES - 1);
         alpha_queue.push_back(b);
      end
   endtask

   task automatic send_beat(input logic [1:0] kind, input logic [2:0] row,
                            input logic [3:0] col, input logic [15:0] prob,
                            input logic [3:0] sym, input logic start);
      int gap;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {4'b0, start, sym, prob, col, row};
      do @(posedge clock); while (!req_tready);
      case (kind)
         hfs_pkg::KIND_TRANS:
            if (col < hfs_pkg::NUM_STATES) trans_mem[row*hfs_pkg::NUM_STATES + col] = prob;
         hfs_pkg::KIND_EMIT: emit_mem[row*hfs_pkg::NUM_SYMBOLS + col] = prob;
         hfs_pkg::KIND_INIT: init_mem[row] = prob;
         default: forward_step(sym, start);
      endcase
      if (!calm && $urandom_range(3) == 0) begin
         gap = $urandom_range(9, 1);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic logic [15:0] rand_prob();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_load_tables();
      for (int r = 0; r < hfs_pkg::NUM_STATES; r++) begin
         send_beat(hfs_pkg::KIND_INIT, 3'(r), 4'($urandom), rand_prob(), 4'($urandom),
                   1'($urandom));
         for (int c = 0; c < hfs_pkg::NUM_STATES; c++)
            send_beat(hfs_pkg::KIND_TRANS, 3'(r), 4'(c), rand_prob(), 4'($urandom),
                      1'($urandom));
         for (int c = 0; c < hfs_pkg::NUM_SYMBOLS; c++)
            send_beat(hfs_pkg::KIND_EMIT, 3'(r), 4'(c), rand_prob(), 4'($urandom),
                      1'($urandom));
      end
   endtask

   task automatic test_continue_before_start();
      send_beat(hfs_pkg::KIND_OBSERVE, 3'd7, 4'd15, 16'hFFFF, 4'd15, 1'b0);
   endtask

   task automatic test_ignored_writes();
      for (int c = hfs_pkg::NUM_STATES; c < 16; c++)
         send_beat(hfs_pkg::KIND_TRANS, 3'($urandom), 4'(c), 16'($urandom), 4'd0, 1'b0);
      send_beat(hfs_pkg::KIND_OBSERVE, 3'd0, 4'd0, 16'd0, 4'd0, 1'b1);
      send_beat(hfs_pkg::KIND_OBSERVE, 3'd0, 4'd0, 16'd0, 4'd0, 1'b0);
   endtask

   task automatic test_zero_scale();
      for (int r = 0; r < hfs_pkg::NUM_STATES; r++)
         send_beat(hfs_pkg::KIND_EMIT, 3'(r), 4'd15, 16'd0, 4'd0, 1'b0);
      send_beat(hfs_pkg::KIND_OBSERVE, 3'd0, 4'd0, 16'hFFFF, 4'd15, 1'b1);
      send_beat(hfs_pkg::KIND_OBSERVE, 3'd0, 4'd0, 16'hFFFF, 4'd15, 1'b0);
      send_beat(hfs_pkg::KIND_OBSERVE, 3'd0, 4'd0, 16'hFFFF, 4'd0, 1'b0);
   endtask

   task automatic test_saturation();
      for (int r = 0; r < hfs_pkg::NUM_STATES; r++) begin
         send_beat(hfs_pkg::KIND_INIT, 3'(r), 4'd0, 16'hFFFF, 4'd0, 1'b0);
         send_beat(hfs_pkg::KIND_EMIT, 3'(r), 4'd15, 16'hFFFF, 4'd0, 1'b0);
      end
      send_beat(hfs_pkg::KIND_OBSERVE, 3'd0, 4'd0, 16'd0, 4'd15, 1'b1);
      send_beat(hfs_pkg::KIND_OBSERVE, 3'd0, 4'd0, 16'd0, 4'd15, 1'b0);
      send_beat(hfs_pkg::KIND_OBSERVE, 3'd0, 4'd0, 16'd0, 4'd15, 1'b0);
   endtask

   task automatic test_random(input int count);
      logic [1:0] kind;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            wait (alpha_queue.size() == 0);
         end
         if (n == count - count / 5) calm = 1'b1;
         kind = ($urandom_range(9) < 6) ? hfs_pkg::KIND_OBSERVE : 2'($urandom_range(2));
         send_beat(kind, 3'($urandom), 4'($urandom), rand_prob(), 4'($urandom),
                   $urandom_range(4) == 0);
      end
   endtask

   always @(negedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      alpha_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (alpha_queue.size() == 0) begin
            $error("unexpected result beat %h", rsp_tdata);
            errors++;
         end else begin
            want = alpha_queue.pop_front();
            if (rsp_tdata[2:0] !== want.state_index) begin
               $error("state_index: expected %0d, got %0d", want.state_index, rsp_tdata[2:0]);
               errors++;
            end
            if (rsp_tdata[19:3] !== want.alpha_value) begin
               $error("alpha_value: expected %0d, got %0d", want.alpha_value, rsp_tdata[19:3]);
               errors++;
            end
            if (rsp_tdata[36:20] !== want.scale) begin
               $error("scale: expected %0d, got %0d", want.scale, rsp_tdata[36:20]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > 20000) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      for (int j = 0; j < hfs_pkg::NUM_STATES; j++) alpha_mem[j] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_load_tables();
      test_continue_before_start();
      test_ignored_writes();
      test_zero_scale();
      test_saturation();
      test_random(30);
      @(negedge clock);
      req_tvalid = 1'b0;
      wait (alpha_queue.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && alpha_queue.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
